// ===== rtl/ckhb_pkg.sv =====
// Shared types, constants and the hash table of the canonical k-mer binner.
// No dependencies; every other file imports this package.

package ckhb_pkg;

   // window geometry
   localparam int MAX_KMER_LENGTH = 64;
   localparam int KLEN_W          = 7;
   localparam int WORD_W          = 64;
   localparam int WIN_W           = 2 * MAX_KMER_LENGTH;
   localparam int WORD_BASES      = WORD_W / 2;
   localparam int WORD_BYTES      = WORD_W / 8;
   localparam int SHIFT_W         = 8;
   localparam int STEP_W          = 5;
   localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(31);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic REG_KMER_LENGTH = 1'b0;

   // request queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // 2-bit base codes
   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // one queued window: masked forward strand, reverse complement, long flag
   typedef struct packed {
      logic [WIN_W-1:0] fwd_win;
      logic [WIN_W-1:0] rev_win;
      logic             long_k;
   } ckhb_entry_type;

   localparam logic [7:0] PEARSON_TABLE [256] = '{
      8'd105, 8'd193, 8'd195, 8'd26,  8'd208, 8'd80,  8'd38,  8'd156,
      8'd128, 8'd2,   8'd101, 8'd205, 8'd75,  8'd116, 8'd139, 8'd61,
      8'd197, 8'd120, 8'd244, 8'd51,  8'd185, 8'd132, 8'd55,  8'd150,
      8'd177, 8'd241, 8'd103, 8'd196, 8'd13,  8'd237, 8'd136, 8'd24,
      8'd211, 8'd56,  8'd207, 8'd9,   8'd30,  8'd145, 8'd18,  8'd167,
      8'd108, 8'd32,  8'd106, 8'd151, 8'd3,   8'd54,  8'd248, 8'd65,
      8'd17,  8'd198, 8'd85,  8'd95,  8'd29,  8'd83,  8'd4,   8'd206,
      8'd188, 8'd186, 8'd107, 8'd255, 8'd129, 8'd35,  8'd142, 8'd91,
      8'd203, 8'd158, 8'd74,  8'd138, 8'd162, 8'd135, 8'd102, 8'd114,
      8'd81,  8'd170, 8'd10,  8'd19,  8'd215, 8'd57,  8'd214, 8'd70,
      8'd37,  8'd163, 8'd231, 8'd227, 8'd152, 8'd14,  8'd40,  8'd84,
      8'd68,  8'd252, 8'd0,   8'd66,  8'd121, 8'd127, 8'd223, 8'd78,
      8'd201, 8'd34,  8'd225, 8'd240, 8'd124, 8'd191, 8'd12,  8'd42,
      8'd92,  8'd209, 8'd1,   8'd31,  8'd130, 8'd100, 8'd28,  8'd224,
      8'd161, 8'd249, 8'd110, 8'd77,  8'd87,  8'd144, 8'd181, 8'd21,
      8'd86,  8'd58,  8'd174, 8'd113, 8'd194, 8'd147, 8'd242, 8'd50,
      8'd59,  8'd48,  8'd250, 8'd88,  8'd184, 8'd245, 8'd45,  8'd44,
      8'd148, 8'd73,  8'd154, 8'd230, 8'd149, 8'd89,  8'd118, 8'd119,
      8'd79,  8'd229, 8'd239, 8'd117, 8'd189, 8'd179, 8'd254, 8'd155,
      8'd20,  8'd176, 8'd157, 8'd212, 8'd36,  8'd123, 8'd234, 8'd46,
      8'd159, 8'd202, 8'd171, 8'd67,  8'd93,  8'd62,  8'd47,  8'd164,
      8'd247, 8'd15,  8'd137, 8'd235, 8'd216, 8'd160, 8'd200, 8'd133,
      8'd140, 8'd172, 8'd192, 8'd221, 8'd131, 8'd111, 8'd218, 8'd210,
      8'd153, 8'd219, 8'd41,  8'd72,  8'd63,  8'd183, 8'd39,  8'd8,
      8'd98,  8'd168, 8'd52,  8'd213, 8'd175, 8'd134, 8'd115, 8'd90,
      8'd82,  8'd16,  8'd226, 8'd220, 8'd251, 8'd69,  8'd243, 8'd233,
      8'd180, 8'd5,   8'd99,  8'd60,  8'd7,   8'd204, 8'd112, 8'd253,
      8'd182, 8'd109, 8'd25,  8'd53,  8'd94,  8'd187, 8'd190, 8'd178,
      8'd97,  8'd49,  8'd126, 8'd6,   8'd64,  8'd143, 8'd169, 8'd173,
      8'd43,  8'd199, 8'd33,  8'd96,  8'd76,  8'd11,  8'd236, 8'd23,
      8'd166, 8'd104, 8'd141, 8'd246, 8'd125, 8'd217, 8'd122, 8'd238,
      8'd27,  8'd22,  8'd228, 8'd146, 8'd165, 8'd71,  8'd232, 8'd222
   };

   // ASCII nucleotide to 2-bit code; anything unknown reads as A
   function automatic logic [1:0] base_code(input logic [7:0] ch);
      logic [1:0] code;
      unique case (ch)
         "C", "c": code = BASE_C;
         "G", "g": code = BASE_G;
         "T", "t": code = BASE_T;
         default:  code = BASE_A;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/ckhb_chan_if.sv =====
// Request and response channel interfaces of the k-mer binner.
// Depends on ckhb_pkg for field widths.

interface ckhb_req_if import ckhb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] base_char;
   logic       sequence_start;

   modport source (output valid, base_char, sequence_start, input ready);
   modport sink   (input valid, base_char, sequence_start, output ready);
endinterface

interface ckhb_rsp_if import ckhb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] kmer_high;
   logic [WORD_W-1:0] kmer_low;
   logic [7:0]        bin;
   logic              reverse_chosen;

   modport source (output valid, kmer_high, kmer_low, bin, reverse_chosen, input ready);
   modport sink   (input valid, kmer_high, kmer_low, bin, reverse_chosen, output ready);
endinterface

// ===== rtl/ckhb_front.sv =====
// Front end: takes requests, rolls the forward and reverse-complement
// history, and queues each full window. Depends on ckhb_pkg, ckhb_req_if.

module ckhb_front import ckhb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [KLEN_W-1:0] kmer_length,
   ckhb_req_if.sink          req_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output ckhb_entry_type    push_entry
);

   logic [WIN_W-1:0]   fwd_ff, fwd_in;
   logic [WIN_W-1:0]   rev_ff, rev_in;
   logic [KLEN_W-1:0]  cnt_ff, cnt_in;
   logic [WIN_W-1:0]   fwd_base, rev_base;
   logic [KLEN_W-1:0]  cnt_base;
   logic [KLEN_W-1:0]  k_eff;
   logic [SHIFT_W-1:0] shamt;
   logic [WIN_W-1:0]   win_mask;
   logic [1:0]         code;
   logic               accept;

   // clamp the window length into 1..MAX
   always_comb begin
      if (kmer_length == '0) begin
         k_eff = KLEN_W'(1);
      end else if (kmer_length > KLEN_W'(MAX_KMER_LENGTH)) begin
         k_eff = KLEN_W'(MAX_KMER_LENGTH);
      end else begin
         k_eff = kmer_length;
      end
   end

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign code         = base_code(req_ch.base_char);

   // history update; a sequence start drops the old bases first
   // (zeros forward, complement of A i.e. all ones in reverse)
   always_comb begin
      fwd_base = req_ch.sequence_start ? '0 : fwd_ff;
      rev_base = req_ch.sequence_start ? '1 : rev_ff;
      cnt_base = req_ch.sequence_start ? '0 : cnt_ff;
      fwd_in   = {fwd_base[WIN_W-3:0], code};
      rev_in   = {~code, rev_base[WIN_W-1:2]};
      cnt_in   = (cnt_base < KLEN_W'(MAX_KMER_LENGTH)) ? cnt_base + KLEN_W'(1) : cnt_base;
   end

   // window extraction: mask the forward strand, align the reverse one
   assign shamt    = SHIFT_W'(WIN_W) - {1'b0, k_eff} - {1'b0, k_eff};
   assign win_mask = {WIN_W{1'b1}} >> shamt;

   always_comb begin
      push_entry.fwd_win = fwd_in & win_mask;
      push_entry.rev_win = rev_in >> shamt;
      push_entry.long_k  = k_eff > KLEN_W'(WORD_BASES);
   end

   assign push_valid = accept && (cnt_in >= k_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         rev_ff <= '1;
         cnt_ff <= '0;
      end else if (accept) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/ckhb_queue.sv =====
// Small FIFO of windows between the front and back ends.
// Depends on ckhb_pkg.

module ckhb_queue import ckhb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  ckhb_entry_type push_entry,
   output logic           pop_valid,
   input  logic           pop_ready,
   output ckhb_entry_type pop_entry
);

   ckhb_entry_type    mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

endmodule

// ===== rtl/ckhb_back.sv =====
// Back end: picks the canonical strand and Pearson-hashes it one byte a cycle
// into an output register; the last byte waits until it is free. Depends on ckhb_pkg.

module ckhb_back import ckhb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  ckhb_entry_type pop_entry,
   ckhb_rsp_if.source     rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HASH = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [WIN_W-1:0]  data_ff, data_in;
   logic [7:0]        hash_ff, hash_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [WIN_W-1:0]  canon_ff, canon_in;
   logic              rev_ff, rev_in;
   logic              out_valid_ff, out_valid_in;
   logic [WIN_W-1:0]  out_kmer_ff;
   logic [7:0]        out_bin_ff;
   logic              out_rev_ff;
   logic              out_load;
   logic              out_free;
   logic              rev_sel;
   logic [WIN_W-1:0]  canon;
   logic [7:0]        hash_next;

   // canonical choice; a tie keeps the forward strand
   assign rev_sel   = pop_entry.rev_win < pop_entry.fwd_win;
   assign canon     = rev_sel ? pop_entry.rev_win : pop_entry.fwd_win;
   assign hash_next = PEARSON_TABLE[hash_ff ^ data_ff[WIN_W-1 -: 8]];
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign pop_ready = state_ff == S_IDLE;

   // sequencer
   always_comb begin
      state_in = state_ff;
      data_in  = data_ff;
      hash_in  = hash_ff;
      steps_in = steps_ff;
      canon_in = canon_ff;
      rev_in   = rev_ff;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               canon_in = canon;
               rev_in   = rev_sel;
               hash_in  = '0;
               if (pop_entry.long_k) begin
                  data_in  = canon;
                  steps_in = STEP_W'(2 * WORD_BYTES);
               end else begin
                  data_in  = {canon[WORD_W-1:0], {(WIN_W-WORD_W){1'b0}}};
                  steps_in = STEP_W'(WORD_BYTES);
               end
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            // the last byte waits until the output register frees up
            if (steps_ff != STEP_W'(1) || out_free) begin
               hash_in  = hash_next;
               data_in  = {data_ff[WIN_W-9:0], 8'h00};
               steps_in = steps_ff - STEP_W'(1);
               if (steps_ff == STEP_W'(1)) begin
                  out_load = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      hash_ff  <= hash_in;
      steps_ff <= steps_in;
      canon_ff <= canon_in;
      rev_ff   <= rev_in;
      if (out_load) begin
         out_kmer_ff <= canon_ff;
         out_bin_ff  <= hash_next;
         out_rev_ff  <= rev_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kmer_high      = out_kmer_ff[WIN_W-1:WORD_W];
   assign rsp_ch.kmer_low       = out_kmer_ff[WORD_W-1:0];
   assign rsp_ch.bin            = out_bin_ff;
   assign rsp_ch.reverse_chosen = out_rev_ff;

endmodule

// ===== rtl/canonical_kmer_hash_binner.sv =====
// Canonical k-mer binner top: k-mer length register, front end, queue, back end.
// Depends on ckhb_pkg, ckhb_chan_if, ckhb_front, ckhb_queue, ckhb_back.
// Requests are taken one per cycle while the 4-deep window queue has room.
// The back end hashes one window at a time, one Pearson byte per cycle (8 bytes for
// k <= 32, 16 for k > 32, the last only once the response register is free), and
// takes the next window from the queue only after the last one is in the response
// register. Synchronous reset clears history, queue and state.

module canonical_kmer_hash_binner import ckhb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ckhb_req_if.sink              req_ch,
   ckhb_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [KLEN_W-1:0] klen_ff;
   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   ckhb_entry_type    push_entry, pop_entry;
   logic              csr_hit;

   // configuration register
   assign pready  = 1'b1;
   assign csr_hit = paddr[CSR_IDX_LSB] == REG_KMER_LENGTH;
   assign prdata  = csr_hit ? CSR_DATA_W'(klen_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= KLEN_RESET;
      end else if (psel && penable && pwrite && csr_hit) begin
         klen_ff <= pwdata[KLEN_W-1:0];
      end
   end

   ckhb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .kmer_length (klen_ff),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   ckhb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   ckhb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== rtl/ckhb_checker.sv =====
// Port-level checks of the k-mer binner, bound to the top level.
// Depends on ckhb_pkg and canonical_kmer_hash_binner.

module ckhb_checker import ckhb_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  psel,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] prdata
);

   // a response waiting on the sink stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the empty queue takes requests as soon as reset drops
   assert property (@(posedge clock) $fell(reset) |-> req_ready)
      else $error("request side not ready after reset");

   // the length register reads back within its 7 bits
   assert property (@(posedge clock) disable iff (reset)
      psel && !pwrite && paddr == '0 |-> prdata[CSR_DATA_W-1:KLEN_W] == '0)
      else $error("length register read has stray bits");

endmodule

bind canonical_kmer_hash_binner ckhb_checker u_ckhb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .psel      (psel),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .prdata    (prdata)
);

// ===== verif/ckhb_canon_checker.sv =====
// Response checker of the canonical k-mer binner: tracks k, predicts every window.
// Depends on ckhb_pkg (widths, hash table) and ckhb_chan_if (channel interfaces).

module ckhb_canon_checker import ckhb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ckhb_req_if                   req_mon,
   ckhb_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    errors,
   output int                    outstanding,
   output int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WORD_W-1:0] kmer_high;
      logic [WORD_W-1:0] kmer_low;
      logic [7:0]        bin;
      logic              reverse_chosen;
   } kmer_result_type;

   // predictor state: raw base history, count, configured length
   logic [WIN_W-1:0]  base_history = '0;
   int                seen_count   = 0;
   logic [KLEN_W-1:0] klen_reg     = KLEN_RESET;
   kmer_result_type   expected_kmers [$];

   initial begin
      errors      = 0;
      outstanding = 0;
      checked     = 0;
   end

   function automatic logic [1:0] char_code(input logic [7:0] ch);
      case (ch)
         "C", "c": return BASE_C;
         "G", "g": return BASE_G;
         "T", "t": return BASE_T;
         default:  return BASE_A;
      endcase
   endfunction

   // zero and out-of-range lengths clamp into 1..MAX
   function automatic int window_len(input logic [KLEN_W-1:0] v);
      int k;
      k = int'(v);
      if (k == 0) k = 1;
      if (k > MAX_KMER_LENGTH) k = MAX_KMER_LENGTH;
      return k;
   endfunction

   // Pearson hash over one word, most significant byte first
   function automatic logic [7:0] pearson_word(input logic [7:0] h, input logic [WORD_W-1:0] w);
      logic [7:0] acc;
      acc = h;
      for (int s = 0; s < WORD_BYTES; s++)
         acc = PEARSON_TABLE[acc ^ w[WORD_W-1-8*s -: 8]];
      return acc;
   endfunction

   function automatic kmer_result_type predict_canonical(input logic [WIN_W-1:0] history,
                                                         input int k);
      logic [WIN_W-1:0] keep, fwd, rc, canon;
      kmer_result_type  r;
      logic [7:0]       h;
      keep = (k >= MAX_KMER_LENGTH) ? '1 : ((WIN_W'(1) << (2 * k)) - WIN_W'(1));
      fwd  = history & keep;
      rc   = '0;
      // complement each base and mirror its position inside the window
      for (int i = 0; i < k; i++)
         rc[2 * (k - 1 - i) +: 2] = ~fwd[2 * i +: 2];
      // a tie keeps the forward strand
      r.reverse_chosen = (rc < fwd);
      canon            = r.reverse_chosen ? rc : fwd;
      r.kmer_high      = canon[WIN_W-1:WORD_W];
      r.kmer_low       = canon[WORD_W-1:0];
      h = 8'd0;
      if (k > WORD_BASES) h = pearson_word(h, r.kmer_high);
      r.bin = pearson_word(h, r.kmer_low);
      return r;
   endfunction

   task automatic note_failure(input string msg);
      errors++;
      if (errors <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      kmer_result_type want, got;
      int              k;
      if (reset) begin
         base_history = '0;
         seen_count   = 0;
         klen_reg     = KLEN_RESET;
         expected_kmers.delete();
      end else begin
         // response side: compare against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.kmer_high, rsp_mon.kmer_low, rsp_mon.bin, rsp_mon.reverse_chosen};
            if (expected_kmers.size() == 0) begin
               note_failure($sformatf("unexpected response high=%h low=%h bin=%h rev=%b",
                                      got.kmer_high, got.kmer_low, got.bin,
                                      got.reverse_chosen));
            end else begin
               want = expected_kmers.pop_front();
               checked++;
               if (got.kmer_high !== want.kmer_high || got.kmer_low !== want.kmer_low ||
                   got.bin !== want.bin || got.reverse_chosen !== want.reverse_chosen)
                  note_failure($sformatf({"mismatch: exp high=%h low=%h bin=%h rev=%b, ",
                                          "got high=%h low=%h bin=%h rev=%b"},
                                         want.kmer_high, want.kmer_low, want.bin,
                                         want.reverse_chosen, got.kmer_high, got.kmer_low,
                                         got.bin, got.reverse_chosen));
            end
         end

         // request side: roll the history, predict once the window is full
         if (req_mon.valid && req_mon.ready) begin
            k = window_len(klen_reg);
            if (req_mon.sequence_start) begin
               base_history = '0;
               seen_count   = 0;
            end
            base_history = {base_history[WIN_W-3:0], char_code(req_mon.base_char)};
            if (seen_count < MAX_KMER_LENGTH) seen_count++;
            if (seen_count >= k)
               expected_kmers.insert(expected_kmers.size(),
                                     predict_canonical(base_history, k));
         end

         // register port
         if (psel && penable && pready &&
             paddr[CSR_ADDR_W-1:CSR_IDX_LSB] == REG_KMER_LENGTH) begin
            if (pwrite)
               klen_reg = pwdata[KLEN_W-1:0];
            else if (prdata !== CSR_DATA_W'(klen_reg))
               note_failure($sformatf("register read: exp %h got %h",
                                      CSR_DATA_W'(klen_reg), prdata));
         end
      end
      outstanding = expected_kmers.size();
   end

endmodule

// ===== verif/canonical_kmer_hash_binner_tb.sv =====
// Testbench top of the canonical k-mer binner: clock, reset, stimulus and verdict.
// Depends on ckhb_pkg, ckhb_chan_if, the binner RTL and ckhb_canon_checker.

module canonical_kmer_hash_binner_tb import ckhb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] ADDR_KMER_LENGTH = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED    = CSR_ADDR_W'(4);
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASE_ITEMS     = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    errors, outstanding, checked;

   // idling knobs shared with the response side
   logic calm     = 1'b0;
   logic hold_rsp = 1'b0;
   int   sent     = 0;
   int   cur_klen = 31;
   int   phases   = 0;

   ckhb_req_if req_if ();
   ckhb_rsp_if rsp_if ();

   canonical_kmer_hash_binner u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ckhb_canon_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .errors      (errors),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("canonical_kmer_hash_binner regression: fail");
      $finish;
   end

   // response side: random back-pressure, one long hold-off on demand
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 10);
         end
      end
   end

   function automatic int window_len(input int v);
      if (v == 0) return 1;
      if (v > MAX_KMER_LENGTH) return MAX_KMER_LENGTH;
      return v;
   endfunction

   function automatic logic [7:0] base_letter(input logic [1:0] code, input logic lower);
      logic [7:0] ch;
      case (code)
         BASE_C:  ch = "C";
         BASE_G:  ch = "G";
         BASE_T:  ch = "T";
         default: ch = "A";
      endcase
      return lower ? (ch | 8'h20) : ch;
   endfunction

   // mostly nucleotides in mixed case, now and then an arbitrary byte
   function automatic logic [7:0] random_char();
      if ($urandom_range(99) < 6) return 8'($urandom_range(255));
      return base_letter(2'($urandom_range(3)), 1'($urandom_range(1)));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_req(input logic [7:0] ch, input logic start);
      if (!calm && $urandom_range(99) < 10) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.base_char      <= ch;
      req_if.sequence_start <= start;
      do @(posedge clock); while (!req_if.ready);
      sent++;
      @(negedge clock);
   endtask

   // stop offering and wait for every pending response plus pipeline slack
   task automatic drain();
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_klen(input int v);
      drain();
      csr_access(1'b1, ADDR_KMER_LENGTH, CSR_DATA_W'(v));
      cur_klen = v;
      phases++;
   endtask

   task automatic run_random(input int n);
      int         target, kind, k, len;
      logic       start;
      logic [1:0] half [32];
      target = sent + n;
      k = window_len(cur_klen);
      while (sent < target) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            // ordinary sequence; a few continue the previous one
            len   = $urandom_range(1, 2 * k + 8);
            start = ($urandom_range(9) != 0);
            for (int j = 0; j < len; j++)
               send_req(random_char(), start && (j == 0));
         end else if (kind < 80 && (k % 2) == 0) begin
            // reverse-complement palindrome: forward and reverse tie
            for (int j = 0; j < k / 2; j++) begin
               half[j] = 2'($urandom_range(3));
               send_req(base_letter(half[j], 1'($urandom_range(1))), j == 0);
            end
            for (int j = k / 2 - 1; j >= 0; j--)
               send_req(base_letter(~half[j], 1'($urandom_range(1))), 1'b0);
         end else begin
            // noise: arbitrary bytes and start flags
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++)
               send_req(8'($urandom_range(255)), 1'($urandom_range(3) == 0));
         end
      end
   endtask

   initial begin
      int klen_plan [13];
      int v;
      klen_plan = '{1, 64, 32, 33, 2, 0, 127, 16, 63, 8, 31, -1, -2};
      req_if.valid          = 1'b0;
      req_if.base_char      = 8'h00;
      req_if.sequence_start = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset value, every letter in both cases, byte extremes
      csr_access(1'b0, ADDR_KMER_LENGTH, '0);
      set_klen(2);
      send_req("A", 1'b1);
      send_req("C", 1'b0);
      send_req("G", 1'b0);
      send_req("T", 1'b0);
      send_req("a", 1'b0);
      send_req("c", 1'b0);
      send_req("g", 1'b0);
      send_req("t", 1'b0);
      send_req(8'h00, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req("T", 1'b1);
      send_req("A", 1'b0);
      send_req("N", 1'b0);
      send_req("x", 1'b0);
      // longer k on the same sequence: stored history already covers it
      set_klen(3);
      send_req("G", 1'b0);
      set_klen(1);
      send_req("G", 1'b1);
      send_req(8'h00, 1'b0);
      // zero length behaves as one
      set_klen(0);
      send_req("t", 1'b1);
      // oversize length behaves as the maximum; window far from full
      set_klen(127);
      send_req("c", 1'b0);
      drain();
      csr_access(1'b1, ADDR_UNMAPPED, CSR_DATA_W'(5));
      csr_access(1'b0, ADDR_KMER_LENGTH, '0);
      send_req("C", 1'b0);

      // random phases over a spread of lengths
      for (int p = 0; p < 13; p++) begin
         v = klen_plan[p];
         if (v == -1) v = $urandom_range(1, MAX_KMER_LENGTH);
         if (v == -2) v = $urandom_range(0, 127);
         set_klen(v);
         calm     = (p == 4);
         hold_rsp = (p == 2);
         if (p == 6) begin
            run_random(PHASE_ITEMS / 2);
            drain();
            run_random(PHASE_ITEMS / 2);
         end else begin
            run_random(PHASE_ITEMS);
         end
      end
      calm = 1'b0;
      csr_access(1'b0, ADDR_KMER_LENGTH, '0);
      drain();

      $display("summary: %0d requests over %0d length settings, %0d responses checked",
               sent, phases, checked);
      if (errors == 0 && outstanding == 0) begin
         $display("canonical_kmer_hash_binner regression: pass");
      end else begin
         $display("canonical_kmer_hash_binner regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ckhb_pkg.sv
rtl/ckhb_chan_if.sv
rtl/ckhb_front.sv
rtl/ckhb_queue.sv
rtl/ckhb_back.sv
rtl/canonical_kmer_hash_binner.sv
rtl/ckhb_checker.sv
verif/ckhb_canon_checker.sv
verif/canonical_kmer_hash_binner_tb.sv
